>>> hdl/lsc_pkg.sv
// shared types and constants of the locked slot cache
`timescale 1ns / 1ps
package lsc_pkg;

  localparam int FRAME_W  = 32;
  localparam int COUNT_W  = 8;
  localparam int SLOT_W   = 3;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOOKUP     = 2'd0,
    ACT_UNLOCK     = 2'd1,
    ACT_UNLOCK_ALL = 2'd2,
    ACT_PURGE      = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT       = 3'd0,
    ST_ALLOC     = 3'd1,
    ST_NOSLOT    = 3'd2,
    ST_DONE      = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_t;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // write request from the sequencer to the slot store
  typedef struct packed {
    logic               tag_we;
    logic               lock_we;
    logic [FRAME_W-1:0] tag;
    logic [COUNT_W-1:0] count;
  } store_wr_t;

endpackage

>>> hdl/locked_slot_cache_round_robin.sv
// locked slot cache: round robin tag store with per-slot lock counts
// a lookup scans the slots from zero for a hit, then on a miss scans round robin from the pointer;
//   unlock reads the lock count and then checks it; unlock all and purge go straight to the result register
// one item at a time: the single tag/lock read port is stepped one slot per cycle
// a new item is taken only after the result of the last one has been accepted
// reset clears valid marks, lock counts and the next pointer at once; tags stay unset
`timescale 1ns / 1ps
module locked_slot_cache_round_robin #(
  parameter int ENTRIES = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // action [1:0], frame_number [33:2], slot_index [36:34], zero [39:37]
  input  logic [lsc_pkg::IN_W-1:0]     in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // status [2:0], slot [5:3], lock_count [13:6], zero [15:14]
  output logic [lsc_pkg::OUT_W-1:0]    out_tdata
);
  import lsc_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HIT_SCAN,
    S_ALLOC_SCAN,
    S_UNLOCK_RD,
    S_UNLOCK_CHK,
    S_OUT
  } state_t;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] a);
    next_idx = (a == LAST_IDX) ? '0 : a + 1'b1;
  endfunction

  // input fields
  action_t            in_action;
  logic [FRAME_W-1:0] in_frame;
  logic [SLOT_W-1:0]  in_slot;
  assign in_action = action_t'(in_tdata[1:0]);
  assign in_frame  = in_tdata[33:2];
  assign in_slot   = in_tdata[36:34];

  state_t              state_r, state_nxt;
  logic [FRAME_W-1:0]  frame_r, frame_nxt;
  logic [IW+2:0]       idx_r, idx_nxt;
  logic [IW-1:0]       rd_addr_r, rd_addr_nxt;
  logic [IW:0]         issued_r, issued_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic                cmp_last_r, cmp_last_nxt;
  logic [IW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [IW-1:0]       ptr_r, ptr_nxt;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [ENTRIES-1:0]  live_r, live_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             status_r, status_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;

  store_wr_t           wr;
  logic [IW-1:0]       wr_addr;
  logic [FRAME_W-1:0]  rd_tag;
  logic [COUNT_W-1:0]  rd_count;

  lsc_store #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_store (
    .clk      (clk),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr_r),
    .rd_tag   (rd_tag),
    .rd_count (rd_count)
  );

  // shared compare unit: count of the slot under test, tag match, slot number out
  logic [COUNT_W-1:0] cmp_count;
  logic [COUNT_W-1:0] chk_count;
  logic               tag_match;
  logic [IW+2:0]      cmp_idx_ext;
  logic [SLOT_W-1:0]  cmp_slot;
  logic               idx_out_of_range;

  assign cmp_count        = live_r[cmp_idx_r] ? rd_count : '0;
  assign chk_count        = live_r[rd_addr_r] ? rd_count : '0;
  assign tag_match        = valid_r[cmp_idx_r] && (rd_tag == frame_r);
  assign cmp_idx_ext      = {3'b000, cmp_idx_r};
  assign cmp_slot         = cmp_idx_ext[SLOT_W-1:0];
  assign idx_out_of_range = (idx_r >= (IW+3)'(ENTRIES));

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    frame_nxt     = frame_r;
    idx_nxt       = idx_r;
    rd_addr_nxt   = rd_addr_r;
    issued_nxt    = issued_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_last_nxt  = cmp_last_r;
    cmp_idx_nxt   = cmp_idx_r;
    ptr_nxt       = ptr_r;
    valid_nxt     = valid_r;
    live_nxt      = live_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    count_nxt     = count_r;
    wr            = '0;
    wr_addr       = cmp_idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          frame_nxt = in_frame;
          idx_nxt   = {IW'(0), in_slot};
          case (in_action)
            ACT_LOOKUP: begin
              rd_addr_nxt  = '0;
              issued_nxt   = '0;
              cmp_vld_nxt  = 1'b0;
              cmp_last_nxt = 1'b0;
              state_nxt    = S_HIT_SCAN;
            end
            ACT_UNLOCK: begin
              rd_addr_nxt = idx_nxt[IW-1:0];
              state_nxt   = S_UNLOCK_RD;
            end
            ACT_UNLOCK_ALL: begin
              live_nxt      = '0;
              status_nxt    = ST_DONE;
              slot_nxt      = '0;
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              state_nxt     = S_OUT;
            end
            default: begin
              live_nxt      = '0;
              valid_nxt     = '0;
              status_nxt    = ST_DONE;
              slot_nxt      = '0;
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              state_nxt     = S_OUT;
            end
          endcase
        end
      end

      // walk slots from zero looking for a valid matching tag
      S_HIT_SCAN: begin
        if (cmp_vld_r && tag_match) begin
          count_nxt     = (cmp_count == COUNT_MAX) ? cmp_count : cmp_count + 1'b1;
          wr.lock_we    = 1'b1;
          wr.count      = count_nxt;
          live_nxt[cmp_idx_r] = 1'b1;
          status_nxt    = ST_HIT;
          slot_nxt      = cmp_slot;
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else if (cmp_vld_r && cmp_last_r) begin
          rd_addr_nxt  = ptr_r;
          issued_nxt   = '0;
          cmp_vld_nxt  = 1'b0;
          cmp_last_nxt = 1'b0;
          state_nxt    = S_ALLOC_SCAN;
        end else begin
          cmp_idx_nxt  = rd_addr_r;
          cmp_vld_nxt  = 1'b1;
          cmp_last_nxt = (issued_r == (IW+1)'(ENTRIES - 1));
          rd_addr_nxt  = next_idx(rd_addr_r);
          issued_nxt   = issued_r + 1'b1;
        end
      end

      // walk slots round robin from the pointer looking for an unlocked one
      S_ALLOC_SCAN: begin
        if (cmp_vld_r && (cmp_count == '0)) begin
          wr.tag_we     = 1'b1;
          wr.lock_we    = 1'b1;
          wr.tag        = frame_r;
          wr.count      = COUNT_W'(1);
          live_nxt[cmp_idx_r]  = 1'b1;
          valid_nxt[cmp_idx_r] = 1'b1;
          ptr_nxt       = next_idx(cmp_idx_r);
          status_nxt    = ST_ALLOC;
          slot_nxt      = cmp_slot;
          count_nxt     = COUNT_W'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else if (cmp_vld_r && cmp_last_r) begin
          status_nxt    = ST_NOSLOT;
          slot_nxt      = '0;
          count_nxt     = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          cmp_idx_nxt  = rd_addr_r;
          cmp_vld_nxt  = 1'b1;
          cmp_last_nxt = (issued_r == (IW+1)'(ENTRIES - 1));
          rd_addr_nxt  = next_idx(rd_addr_r);
          issued_nxt   = issued_r + 1'b1;
        end
      end

      // wait for the registered read of the lock count
      S_UNLOCK_RD: begin
        state_nxt = S_UNLOCK_CHK;
      end

      S_UNLOCK_CHK: begin
        slot_nxt      = idx_r[SLOT_W-1:0];
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
        if (idx_out_of_range) begin
          status_nxt = ST_DONE;
          count_nxt  = '0;
        end else if (chk_count == '0) begin
          status_nxt = ST_UNDERFLOW;
          count_nxt  = '0;
        end else begin
          status_nxt = ST_DONE;
          count_nxt  = chk_count - 1'b1;
          wr.lock_we = 1'b1;
          wr.count   = count_nxt;
          wr_addr    = rd_addr_r;
          live_nxt[rd_addr_r] = 1'b1;
        end
      end

      S_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      valid_r     <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      cmp_last_r  <= 1'b0;
      issued_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      valid_r     <= valid_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      cmp_last_r  <= cmp_last_nxt;
      issued_r    <= issued_nxt;
    end
    frame_r   <= frame_nxt;
    idx_r     <= idx_nxt;
    rd_addr_r <= rd_addr_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    status_r  <= status_nxt;
    slot_r    <= slot_nxt;
    count_r   <= count_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, count_r, slot_r, status_r};

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_tvalid && in_tready))
    else $error("input taken while a result is pending");

  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && status_r == ST_ALLOC) |-> (count_r == COUNT_W'(1)))
    else $error("allocated slot not locked once");

  a_noslot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && status_r == ST_NOSLOT) |-> (slot_r == '0 && count_r == '0))
    else $error("no-slot result carries data");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= LAST_IDX)
    else $error("next pointer out of range");

endmodule

>>> hdl/lsc_store.sv
// tag and lock count memories with one write port and one registered read port
`timescale 1ns / 1ps
module lsc_store #(
  parameter int ENTRIES = 8,
  parameter int IW      = 3
) (
  input  logic                    clk,
  input  lsc_pkg::store_wr_t      wr,
  input  logic [IW-1:0]           wr_addr,
  input  logic [IW-1:0]           rd_addr,
  output logic [lsc_pkg::FRAME_W-1:0] rd_tag,
  output logic [lsc_pkg::COUNT_W-1:0] rd_count
);
  import lsc_pkg::*;

  logic [FRAME_W-1:0] tag_mem  [ENTRIES];
  logic [COUNT_W-1:0] lock_mem [ENTRIES];

  // writes
  always_ff @(posedge clk) begin
    if (wr.tag_we) begin
      tag_mem[wr_addr] <= wr.tag;
    end
    if (wr.lock_we) begin
      lock_mem[wr_addr] <= wr.count;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_tag   <= tag_mem[rd_addr];
    rd_count <= lock_mem[rd_addr];
  end

endmodule

>>> tb/tb_locked_slot_cache_round_robin.sv
// self-checking testbench for the locked slot cache with its own tag/lock predictor
`timescale 1ns / 1ps
module tb_locked_slot_cache_round_robin;
  import lsc_pkg::*;

  localparam int CACHE_SLOTS  = 8;
  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 260;

  // one action waiting to be offered, with the idling that goes with it
  typedef struct {
    action_t            act;
    logic [FRAME_W-1:0] frame;
    logic [SLOT_W-1:0]  idx;
    int unsigned        gap_pct;
    int unsigned        rx_pct;
    bit                 wait_drain;
    bit                 hold;
  } cache_action_t;

  // one reply as the block should return it
  typedef struct {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
  } cache_reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;

  // predictor state
  logic [FRAME_W-1:0]  slot_tag [CACHE_SLOTS];
  logic                slot_valid [CACHE_SLOTS];
  logic [COUNT_W-1:0]  slot_lock [CACHE_SLOTS];
  int unsigned         next_ptr;

  cache_action_t       actions_queued[$];
  cache_reply_t        replies_due[$];
  logic [FRAME_W-1:0]  frame_pool [16];

  logic                in_fire = 1'b0;
  logic                hold_start = 1'b0;
  int unsigned         hold_left = 0;
  int unsigned         rx_pct = 0;
  int unsigned         err_count = 0;
  int unsigned         cycle_count = 0;

  locked_slot_cache_round_robin #(.ENTRIES(CACHE_SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one action to the predicted tag store and return its reply
  function automatic cache_reply_t slot_cache_apply(action_t act, logic [FRAME_W-1:0] frame,
                                                    logic [SLOT_W-1:0] idx);
    cache_reply_t rsp;
    bit           found;
    int unsigned  tgt;
    rsp.status = ST_DONE;
    rsp.slot   = '0;
    rsp.count  = '0;
    found      = 1'b0;
    case (act)
      ACT_LOOKUP: begin
        // lowest valid slot with a matching tag wins
        for (int i = 0; i < CACHE_SLOTS; i++) begin
          if (!found && slot_valid[i] && slot_tag[i] == frame) begin
            if (slot_lock[i] != COUNT_MAX) slot_lock[i] = slot_lock[i] + 1'b1;
            rsp.status = ST_HIT;
            rsp.slot   = SLOT_W'(i);
            rsp.count  = slot_lock[i];
            found      = 1'b1;
          end
        end
        // miss: first unlocked slot from the next pointer on
        for (int i = 0; i < CACHE_SLOTS; i++) begin
          tgt = (next_ptr + i) % CACHE_SLOTS;
          if (!found && slot_lock[tgt] == '0) begin
            slot_tag[tgt]   = frame;
            slot_valid[tgt] = 1'b1;
            slot_lock[tgt]  = 8'd1;
            next_ptr        = (tgt + 1) % CACHE_SLOTS;
            rsp.status      = ST_ALLOC;
            rsp.slot        = SLOT_W'(tgt);
            rsp.count       = 8'd1;
            found           = 1'b1;
          end
        end
        if (!found) rsp.status = ST_NOSLOT;
      end
      ACT_UNLOCK: begin
        rsp.slot = idx;
        if (int'(idx) >= CACHE_SLOTS) begin
          rsp.status = ST_DONE;
        end else if (slot_lock[idx] == '0) begin
          rsp.status = ST_UNDERFLOW;
        end else begin
          slot_lock[idx] = slot_lock[idx] - 1'b1;
          rsp.count      = slot_lock[idx];
        end
      end
      ACT_UNLOCK_ALL: begin
        for (int i = 0; i < CACHE_SLOTS; i++) slot_lock[i] = '0;
      end
      default: begin
        for (int i = 0; i < CACHE_SLOTS; i++) begin
          slot_lock[i]  = '0;
          slot_valid[i] = 1'b0;
        end
      end
    endcase
    return rsp;
  endfunction

  function automatic cache_action_t plain_action(action_t act, logic [FRAME_W-1:0] frame,
                                                 logic [SLOT_W-1:0] idx, int unsigned gap,
                                                 int unsigned rx);
    cache_action_t a;
    a.act        = act;
    a.frame      = frame;
    a.idx        = idx;
    a.gap_pct    = gap;
    a.rx_pct     = rx;
    a.wait_drain = 1'b0;
    a.hold       = 1'b0;
    return a;
  endfunction

  // mostly lookups of a small frame set so that hits and full caches occur
  function automatic cache_action_t random_action(int unsigned gap, int unsigned rx);
    int unsigned        pick;
    logic [FRAME_W-1:0] frame;
    action_t            act;
    pick  = $urandom_range(99);
    frame = ($urandom_range(99) < 85) ? frame_pool[$urandom_range(15)] : $urandom;
    if (pick < 55)      act = ACT_LOOKUP;
    else if (pick < 90) act = ACT_UNLOCK;
    else if (pick < 95) act = ACT_UNLOCK_ALL;
    else                act = ACT_PURGE;
    return plain_action(act, frame, SLOT_W'($urandom_range(7)), gap, rx);
  endfunction

  // driver: offers queued actions at the falling edge
  always @(negedge clk) begin : driver
    cache_action_t head;
    bit            load;
    load = 1'b0;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      hold_start <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      hold_start <= 1'b0;
    end else begin
      if (actions_queued.size() > 0) begin
        head = actions_queued[0];
        if (!(head.wait_drain && replies_due.size() != 0) &&
            $urandom_range(99) >= head.gap_pct)
          load = 1'b1;
      end
      if (load) begin
        void'(actions_queued.pop_front());
        in_tdata   <= {3'b000, head.idx, head.frame, head.act};
        in_tvalid  <= 1'b1;
        rx_pct     <= head.rx_pct;
        hold_start <= head.hold;
      end else begin
        in_tvalid  <= 1'b0;
        hold_start <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted in cycles
  always @(negedge clk) begin
    if (hold_start)         hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // receiver: random stalls on the result side
  always @(negedge clk) begin
    out_tready <= rst_n && hold_left == 0 && $urandom_range(99) >= rx_pct;
  end

  // monitor: checks result transfers, then predicts accepted input transfers
  always @(posedge clk) begin : monitor
    cache_reply_t want;
    cache_reply_t got;
    in_fire <= in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tdata[2:0]);
      got.slot   = out_tdata[5:3];
      got.count  = out_tdata[13:6];
      if (replies_due.size() == 0) begin
        $error("result transfer with no reply due: status %0d slot %0d lock_count %0d",
               got.status, got.slot, got.count);
        err_count++;
      end else begin
        want = replies_due.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          err_count++;
        end
        if (got.slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, got.slot);
          err_count++;
        end
        if (got.count !== want.count) begin
          $error("lock_count: expected %0d, actual %0d", want.count, got.count);
          err_count++;
        end
        if (out_tdata[15:14] !== 2'b00) begin
          $error("padding: expected 0, actual %0d", out_tdata[15:14]);
          err_count++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready)
      replies_due.push_back(slot_cache_apply(action_t'(in_tdata[1:0]), in_tdata[33:2],
                                             in_tdata[36:34]));
  end

  // run limit
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    cache_action_t a;
    int unsigned   gap;
    int unsigned   rx;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      slot_tag[i]   = '0;
      slot_valid[i] = 1'b0;
      slot_lock[i]  = '0;
    end
    next_ptr = 0;
    frame_pool[0] = 32'h0000_0000;
    frame_pool[1] = 32'hffff_ffff;
    frame_pool[2] = 32'hffff_0000;
    for (int i = 3; i < 16; i++) frame_pool[i] = $urandom;

    // directed: allocation, hit, extremes, underflow, full cache, unlock all, purge
    actions_queued.push_back(plain_action(ACT_LOOKUP, 32'h0000_0000, 3'd0, 0, 0));
    actions_queued.push_back(plain_action(ACT_LOOKUP, 32'h0000_0000, 3'd0, 0, 0));
    actions_queued.push_back(plain_action(ACT_LOOKUP, 32'hffff_ffff, 3'd7, 0, 0));
    // the old marker value is an ordinary tag now
    actions_queued.push_back(plain_action(ACT_LOOKUP, 32'hffff_0000, 3'd0, 0, 0));
    actions_queued.push_back(plain_action(ACT_UNLOCK, 32'hffff_ffff, 3'd0, 0, 0));
    actions_queued.push_back(plain_action(ACT_UNLOCK, 32'h0000_0000, 3'd0, 0, 0));
    // unlock at zero
    actions_queued.push_back(plain_action(ACT_UNLOCK, 32'h0000_0000, 3'd0, 0, 0));
    actions_queued.push_back(plain_action(ACT_UNLOCK, 32'hffff_ffff, 3'd7, 0, 0));
    actions_queued.push_back(plain_action(ACT_LOOKUP, 32'h5a5a_5a5a, 3'd5, 0, 0));
    actions_queued.push_back(plain_action(ACT_LOOKUP, 32'ha5a5_a5a5, 3'd2, 0, 0));
    actions_queued.push_back(plain_action(ACT_LOOKUP, 32'h0000_0001, 3'd0, 0, 0));
    actions_queued.push_back(plain_action(ACT_LOOKUP, 32'h0000_0002, 3'd0, 0, 0));
    actions_queued.push_back(plain_action(ACT_LOOKUP, 32'h0000_0003, 3'd0, 0, 0));
    // wraps round to the unlocked slot zero, then the cache is full
    actions_queued.push_back(plain_action(ACT_LOOKUP, 32'h0000_0004, 3'd0, 0, 0));
    actions_queued.push_back(plain_action(ACT_LOOKUP, 32'h0000_0005, 3'd0, 0, 0));
    actions_queued.push_back(plain_action(ACT_LOOKUP, 32'hffff_ffff, 3'd0, 0, 0));
    actions_queued.push_back(plain_action(ACT_UNLOCK_ALL, 32'h0000_0000, 3'd0, 0, 0));
    actions_queued.push_back(plain_action(ACT_LOOKUP, 32'hffff_0000, 3'd0, 0, 0));
    actions_queued.push_back(plain_action(ACT_PURGE, 32'hffff_ffff, 3'd7, 0, 0));
    // stale tag left behind an invalid slot must not hit
    actions_queued.push_back(plain_action(ACT_LOOKUP, 32'hffff_0000, 3'd0, 0, 0));
    actions_queued.push_back(plain_action(ACT_UNLOCK, 32'h0000_0000, 3'd2, 0, 0));
    actions_queued.push_back(plain_action(ACT_LOOKUP, 32'h0000_0000, 3'd0, 0, 0));

    // lock saturation: hammer one frame past the counter maximum
    a = plain_action(ACT_PURGE, 32'h0, 3'd0, 0, 0);
    a.wait_drain = 1'b1;
    actions_queued.push_back(a);
    for (int i = 0; i < 262; i++)
      actions_queued.push_back(plain_action(ACT_LOOKUP, 32'h0000_1234, 3'd0, 0, 0));
    actions_queued.push_back(plain_action(ACT_UNLOCK, 32'h0, 3'd0, 0, 0));
    actions_queued.push_back(plain_action(ACT_LOOKUP, 32'h0000_1234, 3'd0, 0, 0));
    actions_queued.push_back(plain_action(ACT_UNLOCK_ALL, 32'h0, 3'd0, 0, 0));

    // random phases: no idling, sender idle, receiver stalling, both lightly
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin gap = 0;  rx = 0;  end
        1:       begin gap = 84; rx = 0;  end
        2:       begin gap = 0;  rx = 84; end
        default: begin gap = 9;  rx = 9;  end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        a = random_action(gap, rx);
        // sender waits for every reply at the start of each phase
        if (i == 0) a.wait_drain = 1'b1;
        // receiver holds off while the sender keeps offering
        if ((p == 0 || p == 3) && i == 40) a.hold = 1'b1;
        actions_queued.push_back(a);
      end
    end

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    while (actions_queued.size() != 0 || in_tvalid || replies_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
